@@ rtl/ssw_pkg.sv @@
// Spectrum sweep statistics: shared types and constants.
// Used by ssw_store, the top level and the testbench; depends on nothing.
`default_nettype none
package ssw_pkg;
  localparam int HZ_W = 30;
  localparam int LVL_W = 8;
  localparam int BIN_W = 6;
  localparam int RSSI_W = 9;
  localparam int CFG_AW = 2;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 80;

  typedef logic signed [LVL_W-1:0] level_t;
  typedef logic [HZ_W-1:0] hz_t;

  localparam level_t LEVEL_MIN = -8'sd127;
  localparam level_t LEVEL_MAX = -8'sd1;

  localparam logic [CFG_AW-1:0] REG_START = 2'd0;
  localparam logic [CFG_AW-1:0] REG_END = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CURSOR = 2'd2;

  localparam hz_t START_RESET = 30'd433050000;
  localparam hz_t END_RESET = 30'd434790000;
  localparam logic [BIN_W-1:0] CURSOR_RESET = 6'd32;
endpackage
`default_nettype wire

@@ rtl/ssw_store.sv @@
// Per-bin level store: one write port, one registered read port.
// Entries never written since reset read as the minimum level; uses ssw_pkg.
`default_nettype none
module ssw_store #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  we,
  input  wire [AW-1:0]         waddr,
  input  ssw_pkg::level_t      wdata,
  input  wire [AW-1:0]         raddr,
  output ssw_pkg::level_t      rdata
);
  import ssw_pkg::*;

  level_t mem [DEPTH];
  logic [DEPTH-1:0] vld;
  level_t mem_q;
  logic vld_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
    vld_q <= vld[raddr];
  end

  assign rdata = vld_q ? mem_q : LEVEL_MIN;
endmodule
`default_nettype wire

@@ rtl/ssw_div.sv @@
// Divide by a constant through reciprocal multiplication, four 11-bit steps.
// Turns span*bin into the bin frequency offset; depends on nothing.
`default_nettype none
module ssw_div #(
  parameter int NW = 36,
  parameter int DIV = 63
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           start,
  input  wire [NW-1:0]  dividend,
  output logic          busy,
  output logic [NW-1:0] quotient
);
  localparam int SH = NW + 6;
  localparam int CH = 11;
  localparam int NC = 4;
  localparam int MW = CH * NC;
  localparam int PW = NW + MW;
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + 64'(DIV - 1)) / 64'(DIV));

  logic [NW-1:0] x;
  logic [PW-1:0] acc;
  logic [1:0] idx;
  logic [CH-1:0] chunk;
  logic [NW+CH-1:0] part;

  assign chunk = RECIP[CH*idx +: CH];
  assign part = x * chunk;
  assign quotient = acc[SH +: NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (start) begin
      busy <= 1'b1;
      idx <= 2'(NC - 1);
    end else if (busy) begin
      idx <= idx - 1'b1;
      if (idx == 2'd0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= dividend;
      acc <= '0;
    end else if (busy) begin
      acc <= (acc << CH) + PW'(part);
    end
  end
endmodule
`default_nettype wire

@@ rtl/spectrum_sweep_statistics.sv @@
// A sample that does not end a sweep is taken while idle. The final sample of a sweep
// starts the rank passes (one per bit of the level offset), a peak pass, the multiply and
// divide, the cursor read and then one result item per bin, each held until taken.
// Input is not accepted again until the last result item of the sweep has been taken.
// Reset: synchronous, clears position, stores (via valid bits), configuration and state at once.
`default_nettype none
module spectrum_sweep_statistics #(
  parameter int BIN_COUNT = 64
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire [ssw_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // rssi_dbm[8:0]
  input  wire                               s_axis_tuser,  // sample_valid
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // bin_index, bin_level, bin_peak, noise_floor, strongest_level,
  // strongest_freq_hz, cursor_level
  output logic [ssw_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                              m_axis_tlast,
  input  wire                               cfg_we,
  input  wire [ssw_pkg::CFG_AW-1:0]         cfg_addr,
  input  wire [ssw_pkg::HZ_W-1:0]           cfg_wdata
);
  import ssw_pkg::*;

  localparam int AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int RANK = BIN_COUNT / 4;
  localparam int PW = HZ_W + BIN_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RANK = 4'd1;
  localparam logic [3:0] ST_PEAK = 4'd2;
  localparam logic [3:0] ST_MUL = 4'd3;
  localparam logic [3:0] ST_DIVGO = 4'd4;
  localparam logic [3:0] ST_DIV = 4'd5;
  localparam logic [3:0] ST_CUR = 4'd6;
  localparam logic [3:0] ST_CURCAP = 4'd7;
  localparam logic [3:0] ST_EMITRD = 4'd8;
  localparam logic [3:0] ST_EMITCAP = 4'd9;
  localparam logic [3:0] ST_EMIT = 4'd10;

  logic [3:0] state;
  hz_t base_hz, end_hz;
  logic [BIN_W-1:0] sel_bin;
  logic [BIN_W-1:0] pos;
  logic [BIN_W:0] kc;
  logic dv;
  logic [2:0] bsel;
  logic [6:0] ans;
  logic [BIN_W:0] cnt;
  level_t best_level, floor_lvl, cursor_lvl;
  logic [BIN_W-1:0] best_bin;
  logic found;
  hz_t best_freq;
  logic [PW-1:0] prod;

  level_t rssi_c, lv_q, pk_q, decayed, new_peak;
  logic signed [RSSI_W-1:0] rssi;
  logic [AW-1:0] raddr, cur_addr;
  logic lvl_we, pk_we;
  logic [6:0] lv_u, tval;
  logic [BIN_W:0] cnt_next;
  hz_t span;
  logic div_busy;
  logic [PW-1:0] quot;
  logic in_acc, last_bin;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign rssi = s_axis_tdata[RSSI_W-1:0];
  assign last_bin = ({1'b0, pos} >= (BIN_W+1)'(BIN_COUNT - 1));

  always_comb begin
    if (rssi < -9'sd127) begin
      rssi_c = LEVEL_MIN;
    end else if (rssi > -9'sd1) begin
      rssi_c = LEVEL_MAX;
    end else begin
      rssi_c = rssi[LVL_W-1:0];
    end
  end

  assign cur_addr = ({1'b0, sel_bin} >= (BIN_W+1)'(BIN_COUNT)) ?
                    AW'(BIN_COUNT - 1) : sel_bin[AW-1:0];
  assign raddr = (state == ST_CUR) ? cur_addr : kc[AW-1:0];
  assign lvl_we = in_acc && s_axis_tuser;
  assign pk_we = (state == ST_PEAK) && dv;

  assign decayed = (pk_q > LEVEL_MIN) ? level_t'(pk_q - 8'sd1) : LEVEL_MIN;
  assign new_peak = (lv_q > decayed) ? lv_q : decayed;

  assign lv_u = 7'(lv_q + 8'sd127);
  assign tval = ans | (7'd1 << bsel);
  assign cnt_next = (dv && (lv_u < tval)) ? cnt + 1'b1 : cnt;
  assign span = (end_hz > base_hz) ? hz_t'(end_hz - base_hz) : '0;

  ssw_store #(.DEPTH(BIN_COUNT), .AW(AW)) u_level (
    .clk(clk), .rst(rst), .we(lvl_we), .waddr(pos[AW-1:0]), .wdata(rssi_c),
    .raddr(raddr), .rdata(lv_q)
  );

  ssw_store #(.DEPTH(BIN_COUNT), .AW(AW)) u_peak (
    .clk(clk), .rst(rst), .we(pk_we), .waddr(AW'(kc - 1'b1)), .wdata(new_peak),
    .raddr(raddr), .rdata(pk_q)
  );

  ssw_div #(.NW(PW), .DIV(BIN_COUNT - 1)) u_div (
    .clk(clk), .rst(rst), .start(state == ST_DIVGO), .dividend(prod),
    .busy(div_busy), .quotient(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_hz <= START_RESET;
      end_hz <= END_RESET;
      sel_bin <= CURSOR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_START: base_hz <= cfg_wdata;
        REG_END: end_hz <= cfg_wdata;
        REG_CURSOR: sel_bin <= cfg_wdata[BIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos <= '0;
      kc <= '0;
      dv <= 1'b0;
      m_axis_tvalid <= 1'b0;
      floor_lvl <= LEVEL_MIN;
      best_level <= LEVEL_MIN;
      best_freq <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (last_bin) begin
              pos <= '0;
              kc <= '0;
              dv <= 1'b0;
              cnt <= '0;
              ans <= '0;
              bsel <= 3'd6;
              state <= ST_RANK;
            end else begin
              pos <= pos + 1'b1;
            end
          end
        end
        ST_RANK: begin
          if (kc != (BIN_W+1)'(BIN_COUNT)) begin
            cnt <= cnt_next;
            dv <= 1'b1;
            kc <= kc + 1'b1;
          end else begin
            kc <= '0;
            cnt <= '0;
            dv <= 1'b0;
            if (cnt_next <= (BIN_W+1)'(RANK)) begin
              ans <= tval;
            end
            if (bsel == 3'd0) begin
              floor_lvl <= level_t'({1'b0, ((cnt_next <= (BIN_W+1)'(RANK)) ? tval : ans)})
                           + LEVEL_MIN;
              best_level <= LEVEL_MIN;
              found <= 1'b0;
              best_bin <= '0;
              state <= ST_PEAK;
            end else begin
              bsel <= bsel - 1'b1;
            end
          end
        end
        ST_PEAK: begin
          if (dv && (new_peak > best_level)) begin
            best_level <= new_peak;
            best_bin <= BIN_W'(kc - 1'b1);
            found <= 1'b1;
          end
          if (kc != (BIN_W+1)'(BIN_COUNT)) begin
            dv <= 1'b1;
            kc <= kc + 1'b1;
          end else begin
            kc <= '0;
            dv <= 1'b0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod <= span * best_bin;
          state <= ST_DIVGO;
        end
        ST_DIVGO: state <= ST_DIV;
        ST_DIV: begin
          if (!div_busy) begin
            best_freq <= found ? hz_t'(base_hz + quot[HZ_W-1:0]) : '0;
            state <= ST_CUR;
          end
        end
        ST_CUR: state <= ST_CURCAP;
        ST_CURCAP: begin
          cursor_lvl <= lv_q;
          state <= ST_EMITRD;
        end
        ST_EMITRD: state <= ST_EMITCAP;
        ST_EMITCAP: begin
          m_axis_tdata <= {4'd0, cursor_lvl, best_freq, best_level, floor_lvl,
                           pk_q, lv_q, BIN_W'(kc)};
          m_axis_tlast <= (kc == (BIN_W+1)'(BIN_COUNT - 1));
          m_axis_tvalid <= 1'b1;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (m_axis_tlast) begin
              kc <= '0;
              state <= ST_IDLE;
            end else begin
              kc <= kc + 1'b1;
              state <= ST_EMITRD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/ssw_check.sv @@
// Port-level checks for spectrum_sweep_statistics, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module ssw_check (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [79:0] m_axis_tdata,
  input wire        m_axis_tlast
);
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is shown");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not idle after last result");

  a_levels: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[13] && m_axis_tdata[21] && m_axis_tdata[29]
                      && m_axis_tdata[37] && m_axis_tdata[75])
    else $error("reported level not negative");
endmodule

bind spectrum_sweep_statistics ssw_check u_ssw_check (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

@@ test/tb_spectrum_sweep_statistics.sv @@
// Testbench for spectrum_sweep_statistics: sweeps of RSSI samples, per-bin report checks.
// Depends on ssw_pkg and the spectrum_sweep_statistics RTL; self-contained otherwise.
`timescale 1ns / 1ps
`default_nettype none

class sweep_scoreboard;
  typedef struct packed {
    logic [7:0] cursor;
    logic [29:0] best_hz;
    logic [7:0] best_lvl;
    logic [7:0] floor_lvl;
    logic [7:0] peak;
    logic [7:0] level;
    logic [5:0] bin;
    logic last;
  } report_t;

  logic [29:0] base_hz, end_hz;
  logic [5:0] cursor_bin;
  int pos;
  int levels[64];
  int peaks[64];
  report_t pending[$];
  int errors;

  function new();
    base_hz = 30'd433050000;
    end_hz = 30'd434790000;
    cursor_bin = 6'd32;
    pos = 0;
    errors = 0;
    for (int i = 0; i < 64; i++) begin
      levels[i] = -127;
      peaks[i] = -127;
    end
  endfunction

  function void write_reg(logic [1:0] idx, logic [29:0] val);
    if (idx == ssw_pkg::REG_START) base_hz = val;
    else if (idx == ssw_pkg::REG_END) end_hz = val;
    else if (idx == ssw_pkg::REG_CURSOR) cursor_bin = val[5:0];
  endfunction

  function logic [29:0] bin_hz(int b);
    longint span;
    span = (end_hz > base_hz) ? longint'(end_hz - base_hz) : 0;
    return base_hz + 30'((span * b) / 63);
  endfunction

  function void note_sample(logic valid, logic signed [8:0] rssi);
    int v, sorted[64], t, floor_v, best_v;
    logic [29:0] best_f;
    report_t r;
    if (valid) begin
      v = rssi;
      levels[pos] = v < -127 ? -127 : (v > -1 ? -1 : v);
    end
    pos++;
    if (pos < 64) return;
    pos = 0;
    sorted = levels;
    for (int i = 1; i < 64; i++)
      for (int j = i; j > 0 && sorted[j-1] > sorted[j]; j--) begin
        t = sorted[j]; sorted[j] = sorted[j-1]; sorted[j-1] = t;
      end
    floor_v = sorted[16];
    best_v = -127;
    best_f = '0;
    for (int i = 0; i < 64; i++) begin
      t = peaks[i] > -127 ? peaks[i] - 1 : -127;
      peaks[i] = levels[i] > t ? levels[i] : t;
      if (peaks[i] > best_v) begin
        best_v = peaks[i];
        best_f = bin_hz(i);
      end
    end
    for (int k = 0; k < 64; k++) begin
      r.bin = 6'(k);
      r.level = 8'(levels[k]);
      r.peak = 8'(peaks[k]);
      r.floor_lvl = 8'(floor_v);
      r.best_lvl = 8'(best_v);
      r.best_hz = best_f;
      r.cursor = 8'(levels[cursor_bin]);
      r.last = (k == 63);
      pending.push_back(r);
    end
  endfunction

  function void check_report(logic [79:0] data, logic last);
    report_t want, got;
    got = {data[75:0], last};
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected report: data=%h last=%b", data, last);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10)
        $display("report mismatch: expected %h, actual %h", want, got);
    end
  endfunction
endclass

module tb_spectrum_sweep_statistics;
  localparam logic [1:0] REG_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [29:0] cfg_wdata = '0;

  sweep_scoreboard sb;
  bit calm;
  int stall_cycles;

  spectrum_sweep_statistics dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_report(m_axis_tdata, m_axis_tlast);
      m_axis_tready <= calm || ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 20000) begin
      $display("[spectrum_sweep_statistics] ERROR");
      $finish;
    end
  end

  task automatic send_sample(logic valid, logic signed [8:0] rssi);
    while (!calm && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= valid;
    s_axis_tdata <= {7'd0, rssi};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_sample(valid, rssi);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [29:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_sweep(int mode);
    logic signed [8:0] r;
    for (int i = 0; i < 64; i++) begin
      if (mode == 0) r = $signed(9'(-127 + int'($urandom_range(87))));
      else if (mode == 1) r = $signed(9'($urandom));
      else r = $signed(9'(-100 + int'($urandom_range(40))));
      if (mode == 2 && $urandom_range(9) == 0) r = -9'sd20;
      send_sample($urandom_range(9) != 0, r);
    end
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed sweep: extremes, invalid samples, end below start, cursor at last bin
    set_reg(ssw_pkg::REG_START, 30'd1000000000);
    set_reg(ssw_pkg::REG_END, 30'd0);
    set_reg(ssw_pkg::REG_CURSOR, 30'd63);
    send_sample(1'b1, -9'sd256);
    send_sample(1'b1, 9'sd255);
    send_sample(1'b1, -9'sd127);
    send_sample(1'b1, -9'sd128);
    send_sample(1'b1, -9'sd1);
    send_sample(1'b1, 9'sd0);
    send_sample(1'b0, -9'sd50);
    send_sample(1'b1, -9'sd1);
    for (int i = 8; i < 64; i++) send_sample(i % 3 != 0, $signed(9'($urandom)));
    drain();

    // pause until all reports are back, then run with no idling
    set_reg(ssw_pkg::REG_START, 30'($urandom_range(1000000000)));
    set_reg(ssw_pkg::REG_END, 30'($urandom_range(1000000000)));
    set_reg(ssw_pkg::REG_CURSOR, 30'($urandom_range(63)));
    set_reg(REG_NONE, 30'h3FFFFFFF);
    calm = 1'b1;
    random_sweep(2);
    drain();
    calm = 1'b0;

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[spectrum_sweep_statistics] OK");
    else
      $display("[spectrum_sweep_statistics] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
rtl/ssw_pkg.sv
rtl/ssw_store.sv
rtl/ssw_div.sv
rtl/spectrum_sweep_statistics.sv
rtl/ssw_check.sv
test/tb_spectrum_sweep_statistics.sv
